/* rtl/core/cs_pkg.sv */
// Shared types and character constants for the comment stripper.
// No dependencies.
package cs_pkg;

	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	localparam logic REQ_TEXT = 1'b0;
	localparam logic REQ_EOT  = 1'b1;

	// Up to two result bytes produced by one scanned item.
	typedef struct packed {
		logic [1:0] cnt;
		logic [7:0] b0;
		logic [7:0] b1;
	} res_t;

	// One queued output transaction.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} entry_t;

endpackage

/* rtl/core/cs_if.sv */
// Valid/ready channel interfaces for the comment stripper input and output.
// No dependencies.
interface cs_in_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] in_byte;

	modport source (output valid, output req_type, output in_byte, input ready);
	modport sink (input valid, input req_type, input in_byte, output ready);
endinterface

interface cs_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;

	modport source (output valid, output out_byte, output last_of_run, input ready);
	modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

/* rtl/core/cs_scan.sv */
// Scanner: mode state registers and the per-byte comment stripping logic.
// Depends on cs_pkg.
module cs_scan (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             req_type,
	input  logic [7:0]       in_byte,
	output cs_pkg::res_t     res
);

	typedef enum logic [2:0] {
		MODE_NORMAL = 3'd0,
		MODE_SEMI   = 3'd1,
		MODE_LINE   = 3'd2,
		MODE_BLOCK  = 3'd3,
		MODE_BDASH  = 3'd4,
		MODE_STRING = 3'd5
	} scan_mode_t;

	scan_mode_t mode_q, mode_d;
	logic       esc_q, esc_d;
	logic       lhb_q, lhb_d;
	logic       keep_space;
	logic       is_quote;
	cs_pkg::res_t close_res;

	always_comb begin
		keep_space = (mode_q == MODE_NORMAL) || (mode_q == MODE_STRING);
		is_quote   = (in_byte == cs_pkg::CH_DQUOTE) || (in_byte == cs_pkg::CH_SQUOTE);
		if (keep_space) begin
			close_res = '{cnt: 2'd2, b0: cs_pkg::CH_SPACE, b1: cs_pkg::CH_LF};
		end else begin
			close_res = '{cnt: 2'd1, b0: cs_pkg::CH_LF, b1: 8'h00};
		end
	end

	always_comb begin
		mode_d = mode_q;
		esc_d  = esc_q;
		lhb_d  = lhb_q;
		res    = '0;
		if (req_type == cs_pkg::REQ_EOT) begin
			if (lhb_q) begin
				res = close_res;
			end
			mode_d = MODE_NORMAL;
			esc_d  = 1'b0;
			lhb_d  = 1'b0;
		end else if (in_byte == cs_pkg::CH_LF) begin
			res   = close_res;
			esc_d = 1'b0;
			lhb_d = 1'b0;
			if (mode_q == MODE_SEMI || mode_q == MODE_LINE) begin
				mode_d = MODE_NORMAL;
			end else if (mode_q == MODE_BDASH) begin
				mode_d = MODE_BLOCK;
			end
		end else begin
			lhb_d = 1'b1;
			if (in_byte == cs_pkg::CH_CR) begin
				if (mode_q == MODE_SEMI) begin
					mode_d = MODE_LINE;
				end else if (mode_q == MODE_BDASH) begin
					mode_d = MODE_BLOCK;
				end
			end else if (esc_q) begin
				esc_d = 1'b0;
				if (mode_q == MODE_STRING) begin
					res = '{cnt: 2'd1, b0: in_byte, b1: 8'h00};
				end
			end else begin
				unique case (mode_q)
					MODE_SEMI: begin
						mode_d = (in_byte == cs_pkg::CH_DASH) ? MODE_BDASH : MODE_LINE;
					end
					MODE_LINE: begin
						mode_d = MODE_LINE;
					end
					MODE_BLOCK: begin
						if (in_byte == cs_pkg::CH_BSLASH) begin
							esc_d = 1'b1;
						end else if (in_byte == cs_pkg::CH_DASH) begin
							mode_d = MODE_BDASH;
						end
					end
					MODE_BDASH: begin
						if (in_byte == cs_pkg::CH_SEMI) begin
							mode_d = MODE_NORMAL;
						end else if (in_byte == cs_pkg::CH_BSLASH) begin
							mode_d = MODE_BLOCK;
							esc_d  = 1'b1;
						end else if (in_byte != cs_pkg::CH_DASH) begin
							mode_d = MODE_BLOCK;
						end
					end
					MODE_STRING: begin
						if (in_byte == cs_pkg::CH_BSLASH) begin
							esc_d = 1'b1;
						end else if (is_quote) begin
							mode_d = MODE_NORMAL;
						end
						res = '{cnt: 2'd1, b0: in_byte, b1: 8'h00};
					end
					default: begin
						mode_d = MODE_NORMAL;
						if (in_byte == cs_pkg::CH_SEMI) begin
							mode_d = MODE_SEMI;
						end else begin
							if (is_quote) begin
								mode_d = MODE_STRING;
							end
							res = '{cnt: 2'd1, b0: in_byte, b1: 8'h00};
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			esc_q  <= 1'b0;
			lhb_q  <= 1'b0;
		end else if (step) begin
			mode_q <= mode_d;
			esc_q  <= esc_d;
			lhb_q  <= lhb_d;
		end
	end

	a_eot_resets: assert property (@(posedge clk) disable iff (!arst_n)
		step && req_type == cs_pkg::REQ_EOT |=> mode_q == MODE_NORMAL && !esc_q && !lhb_q)
		else $error("scanner state not cleared after end of text");

	a_newline_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && req_type == cs_pkg::REQ_TEXT && in_byte == cs_pkg::CH_LF |=> !esc_q && !lhb_q)
		else $error("escape or line flag survived a newline");

endmodule

/* rtl/core/cs_outq.sv */
// Two-entry result queue that spreads one or two result bytes over the output.
// Depends on cs_pkg.
module cs_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cs_pkg::res_t      res,
	input  logic              pop,
	output cs_pkg::entry_t    head,
	output logic [1:0]        cnt
);

	cs_pkg::entry_t ent_q [2];
	cs_pkg::entry_t ent_d [2];
	logic [1:0]     cnt_q, cnt_d, rem, push_n;
	cs_pkg::entry_t new0, new1;

	always_comb begin
		rem    = cnt_q - {1'b0, pop};
		push_n = push ? res.cnt : 2'd0;
		new0   = '{out_byte: res.b0, last_of_run: (res.cnt == 2'd1)};
		new1   = '{out_byte: res.b1, last_of_run: 1'b1};
		ent_d[0] = pop ? ent_q[1] : ent_q[0];
		ent_d[1] = ent_q[1];
		if (push_n != 2'd0) begin
			if (rem == 2'd0) begin
				ent_d[0] = new0;
			end else begin
				ent_d[1] = new0;
			end
		end
		if (push_n == 2'd2) begin
			ent_d[1] = new1;
		end
		cnt_d = rem + push_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		ent_q[0] <= ent_d[0];
		ent_q[1] <= ent_d[1];
	end

	assign head = ent_q[0];
	assign cnt  = cnt_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, rem} + {1'b0, push_n} <= 3'd2)
		else $error("result queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != 2'd0)
		else $error("result queue popped while empty");

endmodule

/* rtl/core/comment_stripper_unit.sv */
// Comment stripper top level: input register, scanner and result queue.
// Path: input register, then scanner into the result queue, then the output port.
// Throughput: one input per cycle while each yields at most one result and the
// output is ready; a line end yielding a space and a newline sends both in turn.
// Reset: arst_n clears the input stage, the result queue and all scan state at once.
// Depends on cs_pkg, cs_if, cs_scan and cs_outq.
module comment_stripper_unit (
	input  logic          clk,
	input  logic          arst_n,
	cs_in_if.sink         inbound,
	cs_out_if.source      outbound
);

	logic         valid_s1;
	logic         req_type_s1;
	logic [7:0]   in_byte_s1;
	logic         step;
	logic         accept;
	logic         pop;
	logic [1:0]   q_cnt;
	cs_pkg::res_t res;
	cs_pkg::entry_t head;

	assign step           = valid_s1 &&
		({1'b0, res.cnt} + {1'b0, q_cnt} <= 3'd2 + {2'b00, pop});
	assign inbound.ready  = !valid_s1 || step;
	assign accept         = inbound.valid && inbound.ready;
	assign pop            = outbound.valid && outbound.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !step);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_s1 <= inbound.req_type;
			in_byte_s1  <= inbound.in_byte;
		end
	end

	cs_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.req_type (req_type_s1),
		.in_byte  (in_byte_s1),
		.res      (res)
	);

	cs_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (step),
		.res    (res),
		.pop    (pop),
		.head   (head),
		.cnt    (q_cnt)
	);

	assign outbound.valid       = (q_cnt != 2'd0);
	assign outbound.out_byte    = head.out_byte;
	assign outbound.last_of_run = head.last_of_run;

	a_hold_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !step |-> !inbound.ready)
		else $error("input accepted while stage one is held");

endmodule
